>>> rtl/branch_resolution_unit_macros.svh
// assertion macros for the branch resolution unit
`ifndef BRANCH_RESOLUTION_UNIT_MACROS_SVH
`define BRANCH_RESOLUTION_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BRU_ASSERT_IMPLY(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("branch resolution unit: implication check failed");

// next-cycle implication, checked out of reset
`define BRU_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("branch resolution unit: next-cycle check failed");

`endif

>>> rtl/bru_pkg.sv
package bru_pkg;

    // operation codes
    localparam logic [5:0] OP_ACBB   = 6'd0;
    localparam logic [5:0] OP_ACBW   = 6'd1;
    localparam logic [5:0] OP_ACBL   = 6'd2;
    localparam logic [5:0] OP_AOBLEQ = 6'd3;
    localparam logic [5:0] OP_AOBLSS = 6'd4;
    localparam logic [5:0] OP_SOBGEQ = 6'd5;
    localparam logic [5:0] OP_SOBGTR = 6'd6;
    localparam logic [5:0] OP_BNEQ   = 6'd7;
    localparam logic [5:0] OP_BEQL   = 6'd8;
    localparam logic [5:0] OP_BGTR   = 6'd9;
    localparam logic [5:0] OP_BLEQ   = 6'd10;
    localparam logic [5:0] OP_BGEQ   = 6'd11;
    localparam logic [5:0] OP_BLSS   = 6'd12;
    localparam logic [5:0] OP_BGTRU  = 6'd13;
    localparam logic [5:0] OP_BLEQU  = 6'd14;
    localparam logic [5:0] OP_BVC    = 6'd15;
    localparam logic [5:0] OP_BVS    = 6'd16;
    localparam logic [5:0] OP_BCC    = 6'd17;
    localparam logic [5:0] OP_BCS    = 6'd18;
    localparam logic [5:0] OP_BBS    = 6'd19;
    localparam logic [5:0] OP_BBC    = 6'd20;
    localparam logic [5:0] OP_BBSS   = 6'd21;
    localparam logic [5:0] OP_BBCS   = 6'd22;
    localparam logic [5:0] OP_BBSC   = 6'd23;
    localparam logic [5:0] OP_BBCC   = 6'd24;
    localparam logic [5:0] OP_BLBS   = 6'd25;
    localparam logic [5:0] OP_BLBC   = 6'd26;
    localparam logic [5:0] OP_CASEB  = 6'd27;
    localparam logic [5:0] OP_CASEW  = 6'd28;
    localparam logic [5:0] OP_CASEL  = 6'd29;
    localparam logic [5:0] OP_BRB    = 6'd30;
    localparam logic [5:0] OP_BRW    = 6'd31;
    localparam logic [5:0] OP_JMP    = 6'd32;

    // condition code bit positions
    localparam int CC_N = 3;
    localparam int CC_Z = 2;
    localparam int CC_V = 1;
    localparam int CC_C = 0;

    // highest legal register bit position
    localparam logic [31:0] BIT_POS_MAX = 32'd31;

    typedef enum logic [1:0] {
        W_BYTE,
        W_WORD,
        W_LONG
    } width_t;

    // one input transaction
    typedef struct packed {
        logic [5:0]  operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] operand_c;
        logic [31:0] current_pc;
        logic [15:0] displacement;
        logic [3:0]  cond_codes_in;
    } bru_in_t;

    // one result transaction
    typedef struct packed {
        logic [31:0] next_pc;
        logic        branch_taken;
        logic        case_table_read;
        logic [31:0] result_value;
        logic        result_write;
        logic [3:0]  cond_codes_out;
        logic        reserved_fault;
    } bru_res_t;

    // operand width of the acb and case forms
    function automatic width_t width_of(logic [5:0] op);
        width_t w;
        case (op)
            OP_ACBB, OP_CASEB: w = W_BYTE;
            OP_ACBW, OP_CASEW: w = W_WORD;
            default:           w = W_LONG;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] width_mask(width_t w);
        logic [31:0] m;
        case (w)
            W_BYTE:  m = 32'h0000_00ff;
            W_WORD:  m = 32'h0000_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] width_sign(width_t w);
        logic [31:0] s;
        case (w)
            W_BYTE:  s = 32'h0000_0080;
            W_WORD:  s = 32'h0000_8000;
            default: s = 32'h8000_0000;
        endcase
        return s;
    endfunction

    // signed less-than of two masked values, sign bit given by s
    function automatic logic signed_less(logic [31:0] x, logic [31:0] y, logic [31:0] s);
        return (x ^ s) < (y ^ s);
    endfunction

endpackage

>>> rtl/bru_exec.sv
module bru_exec (
    input  bru_pkg::bru_in_t  item,
    output bru_pkg::bru_res_t res
);
    import bru_pkg::*;

    logic [5:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] pc;
    logic [3:0]  cc;
    width_t      wsel;
    logic [31:0] m;
    logic [31:0] s;
    logic [31:0] tgt8;
    logic [31:0] tgt16;

    logic [31:0] acb_lim;
    logic [31:0] acb_add;
    logic [31:0] acb_idx;
    logic [31:0] acb_r;
    logic        acb_v;
    logic        acb_cond;

    logic [31:0] aob_r;
    logic [31:0] sob_r;
    logic        aob_v;
    logic        sob_v;
    logic        aob_cond;
    logic        sob_cond;

    logic        bcc_cond;

    logic        bit_fault;
    logic [31:0] bit_mask;
    logic        bit_old;

    logic [31:0] cs_t;
    logic [31:0] cs_lim;
    logic        cs_in;
    logic [31:0] cs_hit_pc;
    logic [31:0] cs_miss_pc;
    logic [3:0]  cs_cc;

    assign op   = item.operation;
    assign a    = item.operand_a;
    assign b    = item.operand_b;
    assign c    = item.operand_c;
    assign pc   = item.current_pc;
    assign cc   = item.cond_codes_in;
    assign wsel = width_of(op);
    assign m    = width_mask(wsel);
    assign s    = width_sign(wsel);

    // branch targets from byte and word displacements
    assign tgt8  = pc + {{24{item.displacement[7]}}, item.displacement[7:0]};
    assign tgt16 = pc + {{16{item.displacement[15]}}, item.displacement};

    // add compare and branch at width
    assign acb_lim  = a & m;
    assign acb_add  = b & m;
    assign acb_idx  = c & m;
    assign acb_r    = (acb_idx + acb_add) & m;
    assign acb_v    = |(~(acb_idx ^ acb_add) & (acb_idx ^ acb_r) & s);
    assign acb_cond = (|(acb_add & s)) ? !signed_less(acb_r, acb_lim, s)
                                       : !signed_less(acb_lim, acb_r, s);

    // increment and decrement loops, always long
    assign aob_r    = b + 32'd1;
    assign sob_r    = a - 32'd1;
    assign aob_v    = !b[31] && aob_r[31];
    assign sob_v    = a[31] && !sob_r[31];
    assign aob_cond = (op == OP_AOBLEQ) ? !signed_less(a, aob_r, 32'h8000_0000)
                                        : signed_less(aob_r, a, 32'h8000_0000);
    assign sob_cond = (op == OP_SOBGEQ) ? !sob_r[31] : (!sob_r[31] && (sob_r != '0));

    // register bit branches
    assign bit_fault = a > BIT_POS_MAX;
    assign bit_mask  = 32'd1 << a[4:0];
    assign bit_old   = |(b & bit_mask);

    // case range check and table address
    assign cs_t       = (a - b) & m;
    assign cs_lim     = c & m;
    assign cs_in      = cs_t <= cs_lim;
    assign cs_hit_pc  = pc + {cs_t[30:0], 1'b0};
    assign cs_miss_pc = pc + {cs_lim[30:0], 1'b0} + 32'd2;
    assign cs_cc      = {signed_less(cs_t, cs_lim, s), cs_t == cs_lim, 1'b0, cs_t < cs_lim};

    // conditional branch tests
    always_comb
    begin
        case (op)
            OP_BNEQ:  bcc_cond = !cc[CC_Z];
            OP_BEQL:  bcc_cond = cc[CC_Z];
            OP_BGTR:  bcc_cond = !(cc[CC_N] || cc[CC_Z]);
            OP_BLEQ:  bcc_cond = cc[CC_N] || cc[CC_Z];
            OP_BGEQ:  bcc_cond = !cc[CC_N];
            OP_BLSS:  bcc_cond = cc[CC_N];
            OP_BGTRU: bcc_cond = !(cc[CC_C] || cc[CC_Z]);
            OP_BLEQU: bcc_cond = cc[CC_C] || cc[CC_Z];
            OP_BVC:   bcc_cond = !cc[CC_V];
            OP_BVS:   bcc_cond = cc[CC_V];
            OP_BCC:   bcc_cond = !cc[CC_C];
            default:  bcc_cond = cc[CC_C];
        endcase
    end

    // result selection by operation
    always_comb
    begin
        res.next_pc         = pc;
        res.branch_taken    = 1'b0;
        res.case_table_read = 1'b0;
        res.result_value    = '0;
        res.result_write    = 1'b0;
        res.cond_codes_out  = cc;
        res.reserved_fault  = 1'b0;
        case (op)
            OP_ACBB, OP_ACBW, OP_ACBL:
            begin
                res.result_value   = acb_r;
                res.result_write   = 1'b1;
                res.cond_codes_out = {|(acb_r & s), acb_r == '0, acb_v, cc[CC_C]};
                if (acb_cond)
                begin
                    res.next_pc      = tgt16;
                    res.branch_taken = 1'b1;
                end
            end
            OP_AOBLEQ, OP_AOBLSS:
            begin
                res.result_value   = aob_r;
                res.result_write   = 1'b1;
                res.cond_codes_out = {aob_r[31], aob_r == '0, aob_v, cc[CC_C]};
                if (aob_cond)
                begin
                    res.next_pc      = tgt8;
                    res.branch_taken = 1'b1;
                end
            end
            OP_SOBGEQ, OP_SOBGTR:
            begin
                res.result_value   = sob_r;
                res.result_write   = 1'b1;
                res.cond_codes_out = {sob_r[31], sob_r == '0, sob_v, cc[CC_C]};
                if (sob_cond)
                begin
                    res.next_pc      = tgt8;
                    res.branch_taken = 1'b1;
                end
            end
            OP_BNEQ, OP_BEQL, OP_BGTR, OP_BLEQ, OP_BGEQ, OP_BLSS,
            OP_BGTRU, OP_BLEQU, OP_BVC, OP_BVS, OP_BCC, OP_BCS:
            begin
                if (bcc_cond)
                begin
                    res.next_pc      = tgt8;
                    res.branch_taken = 1'b1;
                end
            end
            OP_BBS, OP_BBC, OP_BBSS, OP_BBCS, OP_BBSC, OP_BBCC:
            begin
                if (bit_fault)
                begin
                    res.reserved_fault = 1'b1;
                end
                else
                begin
                    if (op == OP_BBSS || op == OP_BBCS)
                    begin
                        res.result_value = b | bit_mask;
                        res.result_write = 1'b1;
                    end
                    else if (op == OP_BBSC || op == OP_BBCC)
                    begin
                        res.result_value = b & ~bit_mask;
                        res.result_write = 1'b1;
                    end
                    if ((op == OP_BBS || op == OP_BBSS || op == OP_BBSC) ? bit_old : !bit_old)
                    begin
                        res.next_pc      = tgt8;
                        res.branch_taken = 1'b1;
                    end
                end
            end
            OP_BLBS, OP_BLBC:
            begin
                if ((op == OP_BLBS) ? a[0] : !a[0])
                begin
                    res.next_pc      = tgt8;
                    res.branch_taken = 1'b1;
                end
            end
            OP_CASEB, OP_CASEW, OP_CASEL:
            begin
                res.cond_codes_out = cs_cc;
                if (cs_in)
                begin
                    res.next_pc         = cs_hit_pc;
                    res.case_table_read = 1'b1;
                    res.branch_taken    = 1'b1;
                end
                else
                begin
                    res.next_pc = cs_miss_pc;
                end
            end
            OP_BRB:
            begin
                res.next_pc      = tgt8;
                res.branch_taken = 1'b1;
            end
            OP_BRW:
            begin
                res.next_pc      = tgt16;
                res.branch_taken = 1'b1;
            end
            OP_JMP:
            begin
                res.next_pc      = a;
                res.branch_taken = 1'b1;
            end
            default:
            begin
                res.next_pc = pc;
            end
        endcase
    end

endmodule

>>> rtl/branch_resolution_unit.sv
// Branch resolution unit: resolves one branch-class instruction per transaction.
// An accepted transaction lands in the input register, is resolved by the
// combinational branch datapath (bru_exec) and is captured in the result
// register. The result is offered once the result register holds it, so a
// transaction passes the input and then the result register before hand-off.
// One transaction is taken every cycle while out_stall is low. With out_stall
// high the two registers fill, and in_stall rises once both hold work. No
// configuration, no state beyond the two pipeline registers.
`include "branch_resolution_unit_macros.svh"

module branch_resolution_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  operation,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic [31:0] operand_c,
    input  logic [31:0] current_pc,
    input  logic [15:0] displacement,
    input  logic [3:0]  cond_codes_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] next_pc,
    output logic        branch_taken,
    output logic        case_table_read,
    output logic [31:0] result_value,
    output logic        result_write,
    output logic [3:0]  cond_codes_out,
    output logic        reserved_fault
);
    import bru_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    bru_in_t  s1_item_reg;
    bru_in_t  s1_item_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    bru_res_t out_res_reg;
    bru_res_t out_res_next;
    bru_res_t exec_res;
    logic     s2_ready;
    logic     s1_ready;

    // stage advance
    assign s2_ready = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    // resolve datapath
    bru_exec u_exec (
        .item (s1_item_reg),
        .res  (exec_res)
    );

    // next values of both stages
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_item_next   = s1_item_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (s1_ready)
        begin
            s1_valid_next = in_valid;
            if (in_valid)
            begin
                s1_item_next = '{operation:     operation,
                                 operand_a:     operand_a,
                                 operand_b:     operand_b,
                                 operand_c:     operand_c,
                                 current_pc:    current_pc,
                                 displacement:  displacement,
                                 cond_codes_in: cond_codes_in};
            end
        end
        if (s2_ready)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_res_next = exec_res;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        out_res_reg <= out_res_next;
    end

    // result ports
    assign out_valid       = out_valid_reg;
    assign next_pc         = out_res_reg.next_pc;
    assign branch_taken    = out_res_reg.branch_taken;
    assign case_table_read = out_res_reg.case_table_read;
    assign result_value    = out_res_reg.result_value;
    assign result_write    = out_res_reg.result_write;
    assign cond_codes_out  = out_res_reg.cond_codes_out;
    assign reserved_fault  = out_res_reg.reserved_fault;

    // checks
    `BRU_ASSERT_IMPLY(a_case_read_taken, out_valid && case_table_read, branch_taken)
    `BRU_ASSERT_IMPLY(a_fault_quiet, out_valid && reserved_fault, !branch_taken && !result_write)
    `BRU_ASSERT_IMPLY(a_no_write_zero, out_valid && !result_write, result_value == '0)
    `BRU_ASSERT_NEXT(a_stage_moves, s1_valid_reg && s2_ready, out_valid_reg)

endmodule
